>>> sv/cru_pkg.sv
`timescale 1ns / 1ps

package cru_pkg;

	localparam int XX_W      = 28;
	localparam int XY_W      = 29;
	localparam int SUM_W     = XX_W + 1;
	localparam int AC_W      = 2 * XX_W;
	localparam int B2_W      = 2 * XY_W - 1;
	localparam int SSQ_W     = 2 * SUM_W;
	localparam int SSQ_HALF  = SSQ_W / 2;
	localparam int K_W       = 16;
	localparam int KP_W      = K_W + SSQ_HALF;
	localparam int TERM_W    = SSQ_W;
	localparam int BASE_W    = AC_W + 2;
	localparam int RESP_W    = 64;
	localparam int RADS_W    = B2_W + 2;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int SQ_STEPS  = 2;
	localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
	localparam int IDX_W     = 8;

	localparam logic [IDX_W-1:0] REG_MODE = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_K    = IDX_W'(1);
	localparam logic [K_W-1:0]   K_RESET  = K_W'(2621);

	typedef enum logic {
		MODE_HARRIS  = 1'b0,
		MODE_MIN_EIG = 1'b1
	} mode_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_acc_t;

	function automatic sq_acc_t sq_step(sq_acc_t acc, logic [2*SQ_STEPS-1:0] bits);
		sq_acc_t r;
		logic [REM_W-1:0] rem_w;
		logic [REM_W-1:0] trial;
		r = acc;
		for (int i = 0; i < SQ_STEPS; i++) begin
			rem_w = {r.rem[REM_W-3:0], bits[2*SQ_STEPS-1-2*i -: 2]};
			trial = REM_W'({r.root, 2'b01});
			if (rem_w >= trial) begin
				r.rem  = rem_w - trial;
				r.root = {r.root[ROOT_W-2:0], 1'b1};
			end else begin
				r.rem  = rem_w;
				r.root = {r.root[ROOT_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

>>> sv/corner_response_unit.sv
`timescale 1ns / 1ps

// Per-pixel corner response, Harris or minimum eigenvalue.
// Input channel: drive sum_xx, sum_xy, sum_yy and raise start; the item is
// taken at the clock edge where start is high and busy is low. busy stays
// low, so one item can enter in every clock cycle.
// Result channel: done is high for exactly one cycle with response valid in
// that cycle. The receiver cannot stall; results come out in input order.
// From the accepting edge an item passes three stages of input registers
// and multipliers, the square-root pipeline of 16 stages with two root
// bits per stage, and one output stage. Throughput is one item per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0
// is response_mode (0 Harris, 1 minimum eigenvalue), index 1 is harris_k
// (unsigned Q0.16). Other indexes are ignored. cfg_ready stays high; write
// only while no item is in flight.
// Reset (arst_n low) clears all valid bits and loads mode Harris and
// harris_k = 2621; items in flight are dropped.
module corner_response_unit
	import cru_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [XX_W-1:0]          sum_xx,
	input  logic signed [XY_W-1:0]   sum_xy,
	input  logic [XX_W-1:0]          sum_yy,
	output logic                     done,
	output logic signed [RESP_W-1:0] response,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [K_W-1:0]           cfg_data
);

	mode_t          mode_q;
	logic [K_W-1:0] k_q;

	logic              accept;
	logic [SUM_W-1:0]  sum_c;
	logic [XX_W-1:0]   dabs_c;
	logic [XY_W-1:0]   xy_u;
	logic [XY_W-1:0]   babs_c;

	logic              vld_s1;
	logic [XX_W-1:0]   a_s1, c_s1, dabs_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic [XY_W-1:0]   babs_s1;

	logic              vld_s2;
	logic [AC_W-1:0]   ac_s2, d2_s2;
	logic [B2_W-1:0]   b2_s2;
	logic [SSQ_W-1:0]  ssq_s2;
	logic [SUM_W-1:0]  sum_s2;

	logic                     vld_s3;
	logic [KP_W-1:0]          kh_s3, kl_s3;
	logic signed [BASE_W-1:0] base_s3;
	logic [RAD_W-1:0]         rad_s3;
	logic [SUM_W-1:0]         sum_s3;

	logic [TERM_W-1:0]        term_s4;
	logic signed [BASE_W-1:0] base_s4;
	logic signed [RESP_W-1:0] resp_h_s5;
	logic signed [RESP_W-1:0] hd_s [2:SQ_STAGES-1];

	logic             sq_vld_s [SQ_STAGES];
	sq_acc_t          sq_acc_s [SQ_STAGES];
	logic [RAD_W-1:0] sq_rad_s [SQ_STAGES];
	logic [SUM_W-1:0] sq_sum_s [SQ_STAGES];

	logic signed [RESP_W-1:0] resp_e_c;
	logic                     vld_s20;
	logic signed [RESP_W-1:0] resp_s20;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HARRIS;
			k_q    <= K_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data[0]);
				REG_K:    k_q    <= cfg_data;
				default:  ;
			endcase
		end
	end

	// stage 1: sum, absolute difference, magnitude of the cross term
	assign xy_u   = sum_xy;
	assign sum_c  = SUM_W'(sum_xx) + SUM_W'(sum_yy);
	assign dabs_c = (sum_xx >= sum_yy) ? (sum_xx - sum_yy) : (sum_yy - sum_xx);
	assign babs_c = xy_u[XY_W-1] ? (~xy_u + XY_W'(1)) : xy_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= sum_xx;
		c_s1    <= sum_yy;
		sum_s1  <= sum_c;
		dabs_s1 <= dabs_c;
		babs_s1 <= babs_c;

		// stage 2: squares and products
		ac_s2  <= AC_W'(a_s1) * AC_W'(c_s1);
		b2_s2  <= B2_W'(babs_s1) * B2_W'(babs_s1);
		d2_s2  <= AC_W'(dabs_s1) * AC_W'(dabs_s1);
		ssq_s2 <= SSQ_W'(sum_s1) * SSQ_W'(sum_s1);
		sum_s2 <= sum_s1;

		// stage 3: k times the squared sum in two halves, base term, radicand
		kh_s3   <= KP_W'(k_q) * KP_W'(ssq_s2[SSQ_W-1:SSQ_HALF]);
		kl_s3   <= KP_W'(k_q) * KP_W'(ssq_s2[SSQ_HALF-1:0]);
		base_s3 <= $signed(BASE_W'(ac_s2)) - $signed(BASE_W'(b2_s2));
		rad_s3  <= RAD_W'({RADS_W'(d2_s2) + {b2_s2, 2'b00}, 4'b0000});
		sum_s3  <= sum_s2;

		// stages 4 and 5: Harris term and response
		term_s4   <= TERM_W'({kh_s3, 13'b0}) + TERM_W'(kl_s3[KP_W-1:16]);
		base_s4   <= base_s3;
		resp_h_s5 <= RESP_W'(base_s4) - $signed(RESP_W'(term_s4));
	end

	// hold Harris result alongside the root pipeline
	for (genvar j = 2; j < SQ_STAGES; j++) begin : g_hd
		if (j == 2) begin : g_first
			always_ff @(posedge clk) begin
				hd_s[j] <= resp_h_s5;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				hd_s[j] <= hd_s[j-1];
			end
		end
	end

	// square root: two root bits per stage
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
		sq_acc_t          acc_in;
		logic [RAD_W-1:0] rad_in;
		logic [SUM_W-1:0] sum_in;
		logic             vld_in;

		if (j == 0) begin : g_first
			assign acc_in = '0;
			assign rad_in = rad_s3;
			assign sum_in = sum_s3;
			assign vld_in = vld_s3;
		end else begin : g_next
			assign acc_in = sq_acc_s[j-1];
			assign rad_in = sq_rad_s[j-1];
			assign sum_in = sq_sum_s[j-1];
			assign vld_in = sq_vld_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else begin
				sq_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			sq_acc_s[j] <= sq_step(acc_in, rad_in[RAD_W-1-2*SQ_STEPS*j -: 2*SQ_STEPS]);
			sq_rad_s[j] <= rad_in;
			sq_sum_s[j] <= sum_in;
		end
	end

	assign resp_e_c = $signed(RESP_W'({sq_sum_s[SQ_STAGES-1], 19'b0}))
		- $signed(RESP_W'({sq_acc_s[SQ_STAGES-1].root, 17'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s20 <= 1'b0;
		end else begin
			vld_s20 <= sq_vld_s[SQ_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		resp_s20 <= (mode_q == MODE_MIN_EIG) ? resp_e_c : hd_s[SQ_STAGES-1];
	end

	assign done     = vld_s20;
	assign response = resp_s20;

endmodule
